>>> design/pr_pkg.sv
// Shared types, codes and states of the PageRank iterate-and-rank unit.
package pr_pkg;

  typedef enum logic [1:0] {
    MODE_LINK    = 2'd0,
    MODE_CLEAR   = 2'd1,
    MODE_COMPUTE = 2'd2,
    MODE_NONE    = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    REG_DAMPING  = 2'd0,
    REG_TOL      = 2'd1,
    REG_MAX_ITER = 2'd2,
    REG_NODES    = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [5:0] source_node;
    logic [5:0] target_node;
    logic       target_known;
  } in_item_t;

  typedef struct packed {
    logic [5:0]  node_index;
    logic [9:0]  out_degree;
    logic [30:0] rank;
    logic [9:0]  iterations_run;
    logic        last;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_DIV,
    ST_INIT,
    ST_SUM,
    ST_SHARE,
    ST_MUL,
    ST_WRITE,
    ST_COPY,
    ST_CHECK,
    ST_SCAN,
    ST_EMIT
  } state_t;

  // Shared divider request: numerator / denominator, restoring, one bit a cycle.
  typedef struct packed {
    logic        start;
    logic [47:0] num;
    logic [22:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [47:0] quo;
  } div_rsp_t;

endpackage

>>> design/pagerank_iterate_and_rank_unit.sv
// Top level: PageRank power iteration over a RAM-held graph, then ranking.
// Link items keep busy high for 1 cycle after acceptance; unused items are not
// busy at all; clear sweeps the 64 graph rows one per cycle.
// Compute: two divisions (initial rank and teleport term), an init sweep over
// the N ranks, then passes with a serial division per link share, then
// ranking; results are single-cycle strobes.
// Synchronous active-low reset clears control, then the graph is swept clear.
module pagerank_iterate_and_rank_unit #(
  parameter int MAX_NODES = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  pr_pkg::in_item_t  in_item,
  output logic              out_valid,
  output pr_pkg::out_item_t out_item,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [30:0]       cfg_data
);
  localparam int AW = $clog2(MAX_NODES);
  localparam logic [31:0] RANK_ONE = 32'h4000_0000;

  logic [16:0] damp_r;
  logic [30:0] tol_r;
  logic [9:0]  maxit_r;
  logic [6:0]  nodes_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      damp_r  <= 17'd55706;
      tol_r   <= 31'd10737;
      maxit_r <= 10'd100;
      nodes_r <= 7'd64;
    end else if (cfg_we) begin
      unique case (pr_pkg::reg_idx_t'(cfg_index))
        pr_pkg::REG_DAMPING:  damp_r  <= cfg_data[16:0];
        pr_pkg::REG_TOL:      tol_r   <= cfg_data;
        pr_pkg::REG_MAX_ITER: maxit_r <= cfg_data[9:0];
        pr_pkg::REG_NODES:    nodes_r <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // Effective values.
  logic [6:0]  n_eff;
  logic [16:0] d_eff;
  always_comb begin
    n_eff = nodes_r;
    if (nodes_r == 7'd0) n_eff = 7'd1;
    if ({25'd0, nodes_r} > MAX_NODES) n_eff = 7'(MAX_NODES);
    d_eff = (damp_r > 17'd65536) ? 17'd65536 : damp_r;
  end

  pr_pkg::state_t st_r, st_nxt;

  // Graph RAM (row = source) and degree RAM, rank_old / rank_next RAMs.
  logic          g_we, dg_we, ro_we, rn_we;
  logic [AW-1:0] g_wa, g_ra, dg_wa, dg_ra, ro_wa, ro_ra, rn_wa, rn_ra;
  logic [63:0]   g_wd, g_rd;
  logic [9:0]    dg_wd, dg_rd;
  logic [30:0]   ro_wd, ro_rd, rn_wd, rn_rd;

  pr_ram #(.WIDTH(64), .DEPTH(MAX_NODES)) u_graph (
    .clk, .we(g_we), .waddr(g_wa), .wdata(g_wd), .raddr(g_ra), .rdata(g_rd));
  pr_ram #(.WIDTH(10), .DEPTH(MAX_NODES)) u_deg (
    .clk, .we(dg_we), .waddr(dg_wa), .wdata(dg_wd), .raddr(dg_ra), .rdata(dg_rd));
  pr_ram #(.WIDTH(31), .DEPTH(MAX_NODES)) u_rold (
    .clk, .we(ro_we), .waddr(ro_wa), .wdata(ro_wd), .raddr(ro_ra), .rdata(ro_rd));
  pr_ram #(.WIDTH(31), .DEPTH(MAX_NODES)) u_rnext (
    .clk, .we(rn_we), .waddr(rn_wa), .wdata(rn_wd), .raddr(rn_ra), .rdata(rn_rd));

  pr_pkg::div_req_t dreq;
  pr_pkg::div_rsp_t drsp;
  pr_div u_div (.clk, .rst_n, .req(dreq), .rsp(drsp));

  // Datapath registers.
  logic [6:0]    i_r, i_nxt, j_r, j_nxt;
  logic          phase_r, phase_nxt;     // sub-step within a state
  logic [30:0]   init_r, init_nxt;
  logic [30:0]   tele_r, tele_nxt;
  logic          divsel_r, divsel_nxt;   // 0: init rank, 1: teleport
  logic [36:0]   sum_r, sum_nxt;
  logic [53:0]   prod_r, prod_nxt;
  logic [37:0]   diff_r, diff_nxt;
  logic [9:0]    iter_r, iter_nxt;
  logic [63:0]   picked_r, picked_nxt;
  logic [30:0]   top_r, top_nxt;
  logic [5:0]    best_r, best_nxt;
  logic          found_r, found_nxt;
  logic          lnk_pend_r, lnk_pend_nxt;
  pr_pkg::in_item_t item_r, item_nxt;
  logic          outv_nxt;
  pr_pkg::out_item_t outi_nxt;
  logic          outv_r;
  pr_pkg::out_item_t outi_r;

  logic [31:0] rsum;
  logic [30:0] ad;
  logic        accept;

  assign accept = start && (st_r == pr_pkg::ST_IDLE) && !lnk_pend_r;

  // Next state.
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      pr_pkg::ST_IDLE:
        if (accept) begin
          if (pr_pkg::mode_t'(in_item.mode) == pr_pkg::MODE_CLEAR)
            st_nxt = pr_pkg::ST_CLEAR;
          else if (pr_pkg::mode_t'(in_item.mode) == pr_pkg::MODE_COMPUTE)
            st_nxt = pr_pkg::ST_DIV;
        end
      pr_pkg::ST_CLEAR:
        if ({25'd0, i_r} == MAX_NODES - 1) st_nxt = pr_pkg::ST_IDLE;
      pr_pkg::ST_DIV:
        if (drsp.done && divsel_r) st_nxt = pr_pkg::ST_INIT;
      pr_pkg::ST_INIT:
        if (i_r == n_eff - 7'd1)
          st_nxt = (maxit_r == 10'd0) ? pr_pkg::ST_SCAN : pr_pkg::ST_SUM;
      pr_pkg::ST_SUM:
        if (phase_r) st_nxt = pr_pkg::ST_SHARE;
      pr_pkg::ST_SHARE:
        if (drsp.done || !phase_r) begin
          if (j_r == n_eff - 7'd1) st_nxt = pr_pkg::ST_MUL;
          else st_nxt = pr_pkg::ST_SUM;
        end
      pr_pkg::ST_MUL:   st_nxt = pr_pkg::ST_WRITE;
      pr_pkg::ST_WRITE:
        st_nxt = (i_r == n_eff - 7'd1) ? pr_pkg::ST_COPY : pr_pkg::ST_SUM;
      pr_pkg::ST_COPY:
        if (phase_r && i_r == n_eff - 7'd1) st_nxt = pr_pkg::ST_CHECK;
      pr_pkg::ST_CHECK:
        st_nxt = (iter_r < maxit_r && diff_r >= {7'd0, tol_r}) ?
                 pr_pkg::ST_SUM : pr_pkg::ST_SCAN;
      pr_pkg::ST_SCAN:
        if (phase_r && i_r == n_eff - 7'd1) st_nxt = pr_pkg::ST_EMIT;
      pr_pkg::ST_EMIT:
        if (phase_r)
          st_nxt = (j_r == n_eff - 7'd1) ? pr_pkg::ST_IDLE : pr_pkg::ST_SCAN;
      default: st_nxt = pr_pkg::ST_IDLE;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    i_nxt = i_r; j_nxt = j_r; phase_nxt = phase_r;
    init_nxt = init_r; tele_nxt = tele_r; divsel_nxt = divsel_r;
    sum_nxt = sum_r; prod_nxt = prod_r; diff_nxt = diff_r; iter_nxt = iter_r;
    picked_nxt = picked_r; top_nxt = top_r; best_nxt = best_r;
    found_nxt = found_r;
    lnk_pend_nxt = 1'b0; item_nxt = item_r;
    outv_nxt = 1'b0; outi_nxt = outi_r;
    g_we = 1'b0; g_wa = '0; g_wd = '0; g_ra = '0;
    dg_we = 1'b0; dg_wa = '0; dg_wd = '0; dg_ra = '0;
    ro_we = 1'b0; ro_wa = '0; ro_wd = '0; ro_ra = '0;
    rn_we = 1'b0; rn_wa = '0; rn_wd = '0; rn_ra = '0;
    dreq = '0;
    rsum = '0;
    ad = '0;

    // Link add: read row and degree, modify next cycle.
    if (lnk_pend_r) begin
      g_we = 1'b1; g_wa = AW'(item_r.source_node);
      g_wd = g_rd;
      if (item_r.target_known) g_wd[item_r.target_node] = 1'b1;
      dg_we = 1'b1; dg_wa = AW'(item_r.source_node);
      dg_wd = (dg_rd == 10'h3FF) ? dg_rd : dg_rd + 10'd1;
    end

    unique case (st_r)
      pr_pkg::ST_IDLE: begin
        i_nxt = '0; j_nxt = '0; phase_nxt = 1'b0;
        if (accept) begin
          item_nxt = in_item;
          g_ra  = AW'(in_item.source_node);
          dg_ra = AW'(in_item.source_node);
          unique case (pr_pkg::mode_t'(in_item.mode))
            pr_pkg::MODE_LINK:
              lnk_pend_nxt = ({26'd0, in_item.source_node} < MAX_NODES);
            pr_pkg::MODE_COMPUTE: begin
              dreq.start = 1'b1;
              dreq.num   = 48'h0000_4000_0000;
              dreq.den   = {16'd0, n_eff};
              divsel_nxt = 1'b0;
              iter_nxt   = '0;
              picked_nxt = '0;
              found_nxt  = 1'b0;
            end
            default: ;
          endcase
        end
      end
      pr_pkg::ST_CLEAR: begin
        g_we = 1'b1; g_wa = AW'(i_r); g_wd = '0;
        dg_we = 1'b1; dg_wa = AW'(i_r); dg_wd = '0;
        i_nxt = i_r + 7'd1;
      end
      pr_pkg::ST_DIV:
        if (drsp.done) begin
          if (!divsel_r) begin
            init_nxt = drsp.quo[30:0];
            divsel_nxt = 1'b1;
            dreq.start = 1'b1;
            dreq.num = {1'b0, 17'(17'd65536 - d_eff), 30'd0};
            dreq.den = {n_eff, 16'd0};
          end else begin
            tele_nxt = drsp.quo[30:0];
          end
        end
      pr_pkg::ST_INIT: begin
        ro_we = 1'b1; ro_wa = AW'(i_r); ro_wd = init_r;
        i_nxt = (i_r == n_eff - 7'd1) ? 7'd0 : i_r + 7'd1;
        j_nxt = '0; sum_nxt = '0; phase_nxt = 1'b0;
      end
      pr_pkg::ST_SUM: begin
        // Read source j row, degree and old rank.
        g_ra = AW'(j_r); dg_ra = AW'(j_r); ro_ra = AW'(j_r);
        if (!phase_r && j_r == 7'd0 && i_r == 7'd0) diff_nxt = '0;
        phase_nxt = 1'b1;
        if (phase_r) begin
          phase_nxt = 1'b0;
          if (dg_rd != 10'd0 && g_rd[i_r[AW-1:0]]) begin
            dreq.start = 1'b1;
            dreq.num = {17'd0, ro_rd};
            dreq.den = {13'd0, dg_rd};
            phase_nxt = 1'b1;
          end
        end
      end
      pr_pkg::ST_SHARE:
        if (drsp.done || !phase_r) begin
          if (phase_r) sum_nxt = sum_r + {6'd0, drsp.quo[30:0]};
          phase_nxt = 1'b0;
          j_nxt = (j_r == n_eff - 7'd1) ? 7'd0 : j_r + 7'd1;
        end
      pr_pkg::ST_MUL:
        prod_nxt = {17'd0, sum_r} * {37'd0, d_eff};
      pr_pkg::ST_WRITE: begin
        // damped term of one or more saturates regardless of teleport
        rsum = {1'b0, tele_r} + prod_r[47:16];
        if (prod_r[53:46] != 8'd0 || rsum > RANK_ONE) rsum = RANK_ONE;
        rn_we = 1'b1; rn_wa = AW'(i_r); rn_wd = rsum[30:0];
        sum_nxt = '0; j_nxt = '0; phase_nxt = 1'b0;
        i_nxt = (i_r == n_eff - 7'd1) ? 7'd0 : i_r + 7'd1;
        if (i_r == n_eff - 7'd1) iter_nxt = iter_r + 10'd1;
      end
      pr_pkg::ST_COPY: begin
        ro_ra = AW'(i_r); rn_ra = AW'(i_r);
        phase_nxt = ~phase_r;
        if (phase_r) begin
          ad = (ro_rd > rn_rd) ? ro_rd - rn_rd : rn_rd - ro_rd;
          diff_nxt = diff_r + {7'd0, ad};
          ro_we = 1'b1; ro_wa = AW'(i_r); ro_wd = rn_rd;
          i_nxt = (i_r == n_eff - 7'd1) ? 7'd0 : i_r + 7'd1;
        end
      end
      pr_pkg::ST_CHECK: begin
        i_nxt = '0; j_nxt = '0; phase_nxt = 1'b0; found_nxt = 1'b0;
      end
      pr_pkg::ST_SCAN: begin
        ro_ra = AW'(i_r);
        phase_nxt = ~phase_r;
        if (phase_r) begin
          if (!picked_r[i_r[AW-1:0]] && (!found_r || ro_rd >= top_r)) begin
            top_nxt = ro_rd; best_nxt = 6'(i_r); found_nxt = 1'b1;
          end
          i_nxt = (i_r == n_eff - 7'd1) ? 7'd0 : i_r + 7'd1;
        end
      end
      pr_pkg::ST_EMIT: begin
        dg_ra = AW'(best_r);
        phase_nxt = ~phase_r;
        if (phase_r) begin
          picked_nxt[best_r] = 1'b1;
          outv_nxt = 1'b1;
          outi_nxt.node_index = best_r;
          outi_nxt.out_degree = dg_rd;
          outi_nxt.rank = top_r;
          outi_nxt.iterations_run = iter_r;
          outi_nxt.last = (j_r == n_eff - 7'd1);
          j_nxt = j_r + 7'd1; found_nxt = 1'b0; i_nxt = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= pr_pkg::ST_CLEAR;
      i_r <= '0; j_r <= '0; phase_r <= 1'b0;
      lnk_pend_r <= 1'b0; outv_r <= 1'b0; divsel_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      i_r <= i_nxt; j_r <= j_nxt; phase_r <= phase_nxt;
      lnk_pend_r <= lnk_pend_nxt; outv_r <= outv_nxt; divsel_r <= divsel_nxt;
    end
    init_r <= init_nxt; tele_r <= tele_nxt; sum_r <= sum_nxt; prod_r <= prod_nxt;
    diff_r <= diff_nxt; iter_r <= iter_nxt; picked_r <= picked_nxt;
    top_r <= top_nxt; best_r <= best_nxt; found_r <= found_nxt;
    item_r <= item_nxt; outi_r <= outi_nxt;
  end

  assign busy      = (st_r != pr_pkg::ST_IDLE) || lnk_pend_r;
  assign out_valid = outv_r;
  assign out_item  = outi_r;
endmodule

>>> design/pr_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
module pr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> design/pr_div.sv
// Iterative restoring divider, one quotient bit per cycle.
module pr_div (
  input  logic             clk,
  input  logic             rst_n,
  input  pr_pkg::div_req_t req,
  output pr_pkg::div_rsp_t rsp
);
  logic [47:0] quo_r, quo_nxt;
  logic [22:0] rem_r, rem_nxt;
  logic [22:0] den_r, den_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [23:0] trial;

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, quo_r[47]};
    if (req.start) begin
      quo_nxt  = req.num;
      rem_nxt  = '0;
      den_nxt  = req.den;
      cnt_nxt  = 6'd0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = 23'(trial - {1'b0, den_r});
        quo_nxt = {quo_r[46:0], 1'b1};
      end else begin
        rem_nxt = trial[22:0];
        quo_nxt = {quo_r[46:0], 1'b0};
      end
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd47) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    cnt_r <= cnt_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;
endmodule

>>> design/pr_checker.sv
// Port-level checks for the PageRank unit, bound to the top level.
module pr_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_valid,
  input pr_pkg::out_item_t out_item
);
  a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy)) else $error("result while idle");
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.last) |=> !out_valid) else $error("result after last");
  a_result_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("results back to back");
  a_rank_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.rank <= 31'h4000_0000) else $error("rank above one");
  a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start)) else $error("busy without a transaction");
endmodule

bind pagerank_iterate_and_rank_unit pr_checker u_pr_checker (
  .clk, .rst_n, .start, .busy, .out_valid, .out_item);

>>> tb/pagerank_rank_checker.sv
// Checker for the PageRank unit: tracks the graph, predicts rankings, compares results.
module pagerank_rank_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  pr_pkg::in_item_t  in_item,
  input  logic              out_valid,
  input  pr_pkg::out_item_t out_item,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [30:0]       cfg_data,
  output int                fail_count,
  output int                pending
);
  import pr_pkg::*;

  localparam logic [63:0] RANK_ONE = 64'd1 << 30;

  logic [63:0] adj_rows [64];
  logic [9:0]  degrees [64];
  logic [16:0] damping;
  logic [30:0] tolerance;
  logic [9:0]  max_iter;
  logic [6:0]  node_count;
  out_item_t   ranking_q [$];

  initial begin
    fail_count = 0;
    pending = 0;
  end

  task automatic flag_mismatch(string what, longint got, longint want);
    $display("[%0t] MISMATCH %s: got %0d expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  task automatic rank_graph();
    int n, iter, best;
    logic [63:0] d, tele, diff, sum, r, top;
    logic [63:0] cur [64];
    logic [63:0] nxt [64];
    bit taken [64];
    bit found;
    out_item_t o;
    n = node_count;
    if (n == 0) n = 1;
    if (n > 64) n = 64;
    d = (damping > 17'd65536) ? 64'd65536 : 64'(damping);
    for (int i = 0; i < n; i++) begin
      cur[i] = RANK_ONE / 64'(n);
      taken[i] = 0;
    end
    tele = ((64'd65536 - d) << 30) / (64'd65536 * 64'(n));
    diff = 64'(tolerance);
    iter = 0;
    while (iter < max_iter && diff >= 64'(tolerance)) begin
      iter++;
      for (int i = 0; i < n; i++) begin
        sum = 0;
        for (int j = 0; j < n; j++)
          if (degrees[j] != 0 && adj_rows[j][i]) sum += cur[j] / 64'(degrees[j]);
        r = tele + ((d * sum) >> 16);
        nxt[i] = (r > RANK_ONE) ? RANK_ONE : r;
      end
      diff = 0;
      for (int i = 0; i < n; i++) begin
        diff += (cur[i] > nxt[i]) ? cur[i] - nxt[i] : nxt[i] - cur[i];
        cur[i] = nxt[i];
      end
    end
    // ties resolve toward the higher index via >=
    for (int k = 0; k < n; k++) begin
      best = 0;
      top = 0;
      found = 0;
      for (int i = 0; i < n; i++)
        if (!taken[i] && (!found || cur[i] >= top)) begin
          best = i;
          top = cur[i];
          found = 1;
        end
      taken[best] = 1;
      o.node_index = 6'(best);
      o.out_degree = degrees[best];
      o.rank = top[30:0];
      o.iterations_run = 10'(iter);
      o.last = (k + 1 == n);
      ranking_q.push_back(o);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 64; i++) begin
        adj_rows[i] = '0;
        degrees[i] = '0;
      end
      damping = 17'd55706;
      tolerance = 31'd10737;
      max_iter = 10'd100;
      node_count = 7'd64;
      ranking_q.delete();
    end else begin
      if (out_valid) begin
        if (ranking_q.size() == 0) begin
          flag_mismatch("unexpected transaction, node_index", out_item.node_index, 0);
        end else begin
          out_item_t want;
          want = ranking_q.pop_front();
          if (out_item.node_index !== want.node_index)
            flag_mismatch("node_index", out_item.node_index, want.node_index);
          if (out_item.out_degree !== want.out_degree)
            flag_mismatch("out_degree", out_item.out_degree, want.out_degree);
          if (out_item.rank !== want.rank)
            flag_mismatch("rank", out_item.rank, want.rank);
          if (out_item.iterations_run !== want.iterations_run)
            flag_mismatch("iterations_run", out_item.iterations_run, want.iterations_run);
          if (out_item.last !== want.last)
            flag_mismatch("last", out_item.last, want.last);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_DAMPING:  damping = cfg_data[16:0];
          REG_TOL:      tolerance = cfg_data;
          REG_MAX_ITER: max_iter = cfg_data[9:0];
          REG_NODES:    node_count = cfg_data[6:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        case (in_item.mode)
          MODE_LINK: begin
            if (degrees[in_item.source_node] != 10'h3FF)
              degrees[in_item.source_node]++;
            if (in_item.target_known)
              adj_rows[in_item.source_node][in_item.target_node] = 1'b1;
          end
          MODE_CLEAR: begin
            for (int i = 0; i < 64; i++) begin
              adj_rows[i] = '0;
              degrees[i] = '0;
            end
          end
          MODE_COMPUTE: rank_graph();
          default: ;
        endcase
      end
    end
    pending = ranking_q.size();
  end
endmodule

>>> tb/pagerank_iterate_and_rank_unit_tb.sv
// Testbench top: drives links, clears, computes and register writes; gives the verdict.
module pagerank_iterate_and_rank_unit_tb;
  import pr_pkg::*;

  logic      clk = 0;
  logic      rst_n = 0;
  logic      start = 0;
  logic      busy;
  in_item_t  in_item = '0;
  logic      out_valid;
  out_item_t out_item;
  logic        cfg_we = 0;
  logic [1:0]  cfg_index = '0;
  logic [30:0] cfg_data = '0;
  int fail_count, pending;
  int sent = 0;
  int idle_pct = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  pagerank_iterate_and_rank_unit uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  pagerank_rank_checker chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  // returns at the edge where the transaction was taken with start still high, or after random idle gaps with start low
  task automatic send(logic [1:0] mode, logic [5:0] src, logic [5:0] dst, logic known);
    start <= 1'b1;
    in_item <= '{mode: mode, source_node: src, target_node: dst, target_known: known};
    @(posedge clk);
    while (busy) @(posedge clk);
    sent++;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [30:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_regs(logic [30:0] d, logic [30:0] tol, logic [30:0] mi, logic [30:0] n);
    write_reg(REG_DAMPING, d);
    write_reg(REG_TOL, tol);
    write_reg(REG_MAX_ITER, mi);
    write_reg(REG_NODES, n);
  endtask

  // a clear, then a random graph on n nodes, mostly well formed, with some stray links and unused items, then a compute
  task automatic graph_episode(int n);
    int links;
    links = $urandom_range(1, 3 * n + 2);
    send(MODE_CLEAR, 6'($urandom), 6'($urandom), 1'($urandom));
    for (int i = 0; i < links; i++) begin
      case ($urandom_range(9))
        0: send(MODE_LINK, 6'($urandom), 6'($urandom), 1'($urandom));
        1: send(MODE_NONE, 6'($urandom), 6'($urandom), 1'($urandom));
        default: send(MODE_LINK, 6'($urandom_range(n - 1)), 6'($urandom_range(n - 1)),
                      $urandom_range(9) != 0);
      endcase
    end
    send(MODE_COMPUTE, 6'($urandom), 6'($urandom), 1'($urandom));
  endtask

  initial begin
    int n, pct [4];
    logic [30:0] d;
    pct = '{0, 72, 36, 0};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    repeat (70) @(posedge clk);

    // directed: uniform ranks on the full graph, then one full pass
    set_regs(31'd55706, 31'd10737, 31'd0, 31'd64);
    send(MODE_LINK, 6'd0, 6'd0, 1'b1);
    send(MODE_LINK, 6'd63, 6'd63, 1'b1);
    send(MODE_LINK, 6'd63, 6'd0, 1'b0);
    send(MODE_LINK, 6'd0, 6'd63, 1'b1);
    send(MODE_LINK, 6'd0, 6'd63, 1'b1);
    send(MODE_LINK, 6'd5, 6'd62, 1'b1);
    send(MODE_NONE, 6'd63, 6'd63, 1'b1);
    send(MODE_COMPUTE, 6'd0, 6'd0, 1'b0);
    write_reg(REG_MAX_ITER, 31'd1);
    send(MODE_COMPUTE, 6'd63, 6'd63, 1'b1);
    // node count zero and above the maximum
    set_regs(31'd131071, 31'd0, 31'd0, 31'd0);
    send(MODE_COMPUTE, 6'd0, 6'd0, 1'b0);
    write_reg(REG_NODES, 31'd127);
    send(MODE_COMPUTE, 6'd0, 6'd0, 1'b0);
    // single node, zero tolerance, every pass runs
    set_regs(31'd65536, 31'd0, 31'd1023, 31'd1);
    send(MODE_COMPUTE, 6'd0, 6'd0, 1'b0);
    // huge tolerance stops after the first pass; ties on an empty graph
    set_regs(31'd0, 31'h7FFF_FFFF, 31'd5, 31'd4);
    send(MODE_CLEAR, 6'd0, 6'd0, 1'b0);
    send(MODE_LINK, 6'd1, 6'd2, 1'b1);
    send(MODE_COMPUTE, 6'd0, 6'd0, 1'b0);
    send(MODE_CLEAR, 6'd0, 6'd0, 1'b0);
    send(MODE_COMPUTE, 6'd0, 6'd0, 1'b0);
    // many duplicate links on node 0
    set_regs(31'd65536, 31'd1000, 31'd3, 31'd3);
    for (int i = 0; i < 40; i++) send(MODE_LINK, 6'd0, 6'(i % 3), 1'b1);
    send(MODE_LINK, 6'd1, 6'd0, 1'b1);
    send(MODE_COMPUTE, 6'd0, 6'd0, 1'b0);
    drain();
    sent = 0;

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = pct[ph];
      while (sent < (ph + 1) * 80) begin
        if ($urandom_range(4) == 0) n = $urandom_range(9, 16);
        else n = $urandom_range(1, 8);
        case ($urandom_range(4))
          0: d = 31'd0;
          1: d = 31'($urandom_range(65536, 131071));
          default: d = 31'($urandom_range(30000, 65536));
        endcase
        set_regs(d, 31'($urandom_range(0, 1 << 20)),
                 31'((n > 8) ? $urandom_range(0, 2) : $urandom_range(0, 6)),
                 31'(($urandom_range(7) == 0) ? $urandom_range(0, 127) % 9 : n));
        graph_episode(n);
        if ($urandom_range(3) == 0) drain();
      end
    end

    drain();
    repeat (200) @(posedge clk);
    if (fail_count == 0)
      $display("pagerank_iterate_and_rank_unit verification clean");
    else
      $display("pagerank_iterate_and_rank_unit verification failed");
    $finish;
  end

  initial begin
    #200_000_000;
    $display("pagerank_iterate_and_rank_unit verification failed");
    $finish;
  end
endmodule

>>> pagerank_iterate_and_rank_unit.f
design/pr_pkg.sv
design/pr_ram.sv
design/pr_div.sv
design/pagerank_iterate_and_rank_unit.sv
design/pr_checker.sv
tb/pagerank_rank_checker.sv
tb/pagerank_iterate_and_rank_unit_tb.sv
